/* hw/rtl/rcps_pkg.sv */
// Shared constants and state encoding for the cyclic permutation shuffle block.
package rcps_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 6;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_INIT  = 9'b000000010,
        B_BREAD = 9'b000000100,
        B_MODS  = 9'b000001000,
        B_MODW  = 9'b000010000,
        B_PREAD = 9'b000100000,
        B_SWAPI = 9'b001000000,
        B_SWAPJ = 9'b010000000,
        B_EMIT  = 9'b100000000
    } back_state_t;

endpackage

/* hw/rtl/rcps_front.sv */
// Front end: size register, byte intake, byte store and run hand-off.
module rcps_front #(
    parameter int MAX_SIZE = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rcps_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rcps_pkg::BYTE_W-1:0]         random_byte,
    input  logic                                q_valid,
    output logic                                q_push,
    output logic [$clog2(MAX_SIZE+1)-1:0]       q_size,
    input  logic                                bytes_busy,
    input  logic [$clog2(MAX_SIZE)-1:0]         byte_rd_addr,
    output logic [rcps_pkg::BYTE_W-1:0]         byte_rdata
);
    import rcps_pkg::*;

    localparam int AW = $clog2(MAX_SIZE);
    localparam int SW = $clog2(MAX_SIZE + 1);

    logic [CFG_W-1:0]  perm_size_reg;
    logic [CFG_W-1:0]  eff_size;
    logic [SW-1:0]     run_size;
    logic [AW-1:0]     load_count_reg;
    logic [AW-1:0]     load_count_next;
    logic              accept;
    logic              complete;
    logic [BYTE_W-1:0] byte_mem [MAX_SIZE];
    logic [BYTE_W-1:0] byte_rdata_reg;

    // Clamp the size: zero acts as one, anything above the store depth saturates.
    always_comb
    begin
        if (perm_size_reg == '0)
        begin
            eff_size = CFG_W'(1);
        end
        else if (perm_size_reg > CFG_W'(MAX_SIZE))
        begin
            eff_size = CFG_W'(MAX_SIZE);
        end
        else
        begin
            eff_size = perm_size_reg;
        end
    end

    assign run_size = SW'(eff_size);
    assign in_ready = !q_valid && !bytes_busy;
    assign accept   = in_valid && in_ready;
    assign complete = (SW'(load_count_reg) + SW'(1)) >= run_size;
    assign q_push   = accept && complete;
    assign q_size   = run_size;

    always_comb
    begin
        load_count_next = load_count_reg;
        if (accept)
        begin
            load_count_next = complete ? '0 : load_count_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_size_reg  <= SIZE_RESET;
            load_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                perm_size_reg <= cfg_wr_data;
            end
            load_count_reg <= load_count_next;
        end
    end

    // Byte store: one write port for intake, one registered read port for the back end.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_mem[load_count_reg] <= random_byte;
        end
        byte_rdata_reg <= byte_mem[byte_rd_addr];
    end

    assign byte_rdata = byte_rdata_reg;

endmodule

/* hw/rtl/rcps_queue.sv */
// Two-entry run queue between the front and back ends.
module rcps_queue #(
    parameter int WIDTH = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] q_data
);
    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);
    assign q_valid = count_reg != 2'd0;
    assign q_data  = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/rcps_mod.sv */
// Bit-serial remainder unit: byte modulo a narrow divisor, one bit per cycle.
module rcps_mod #(
    parameter int MAX_SIZE = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rcps_pkg::BYTE_W-1:0]   dividend,
    input  logic [$clog2(MAX_SIZE)-1:0]   divisor,
    output logic                          done,
    output logic [$clog2(MAX_SIZE)-1:0]   rem
);
    import rcps_pkg::*;

    localparam int AW = $clog2(MAX_SIZE);
    localparam int CW = $clog2(BYTE_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [BYTE_W-1:0] dvd_reg;
    logic [AW-1:0]     dsr_reg;
    logic [AW-1:0]     rem_reg;
    logic [AW:0]       trial;
    logic [AW:0]       diff;

    // Shift in the next dividend bit, subtract when it fits.
    assign trial = {rem_reg, dvd_reg[BYTE_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(BYTE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[BYTE_W-2:0], 1'b0};
            rem_reg <= (trial >= {1'b0, dsr_reg}) ? diff[AW-1:0] : trial[AW-1:0];
        end
        else if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* hw/rtl/rcps_back.sv */
// Back end: identity fill, Sattolo swaps over the permutation store, and entry output.
module rcps_back #(
    parameter int MAX_SIZE = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  logic [$clog2(MAX_SIZE+1)-1:0]      q_size,
    output logic                               q_pop,
    output logic                               bytes_busy,
    output logic [$clog2(MAX_SIZE)-1:0]        byte_rd_addr,
    input  logic [rcps_pkg::BYTE_W-1:0]        byte_rdata,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rcps_pkg::VALUE_W-1:0]       perm_value,
    output logic                               last_entry
);
    import rcps_pkg::*;

    localparam int AW = $clog2(MAX_SIZE);
    localparam int SW = $clog2(MAX_SIZE + 1);

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [SW-1:0] size_reg;
    logic [SW-1:0] size_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] i_next;
    logic [SW-1:0] k_reg;
    logic [SW-1:0] k_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          last_reg;
    logic [AW-1:0] size_m1;
    logic          load_en;
    logic          out_free;
    logic          mod_start;
    logic          mod_done;
    logic [AW-1:0] mod_rem;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_wdata;
    logic          rd_a_en;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rdata_a_reg;
    logic [AW-1:0] rdata_b_reg;
    logic [AW-1:0] perm_mem [MAX_SIZE];

    assign size_m1  = AW'(size_reg - SW'(1));
    assign out_free = !out_valid_reg || out_ready;
    assign load_en  = (state_reg == B_EMIT) && (k_reg != size_reg) && out_free;
    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign mod_start = state_reg == B_MODS;
    assign bytes_busy = (state_reg != B_IDLE) && (state_reg != B_EMIT);
    assign byte_rd_addr = i_reg;

    rcps_mod #(
        .MAX_SIZE (MAX_SIZE)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (byte_rdata),
        .divisor  (i_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    size_next  = q_size;
                    idx_next   = '0;
                    state_next = B_INIT;
                end
            end
            B_INIT:
            begin
                if (idx_reg == size_m1)
                begin
                    if (size_m1 == '0)
                    begin
                        k_next     = '0;
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        i_next     = size_m1;
                        state_next = B_BREAD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            B_BREAD: state_next = B_MODS;
            B_MODS:  state_next = B_MODW;
            B_MODW:
            begin
                if (mod_done)
                begin
                    state_next = B_PREAD;
                end
            end
            B_PREAD: state_next = B_SWAPI;
            B_SWAPI: state_next = B_SWAPJ;
            B_SWAPJ:
            begin
                if (i_reg == AW'(1))
                begin
                    k_next     = '0;
                    state_next = B_EMIT;
                end
                else
                begin
                    i_next     = i_reg - AW'(1);
                    state_next = B_BREAD;
                end
            end
            B_EMIT:
            begin
                if (load_en)
                begin
                    k_next = k_reg + SW'(1);
                end
                if ((k_reg == size_reg) && out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            size_reg      <= '0;
            idx_reg       <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            idx_reg       <= idx_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Permutation store: one write port, two registered read ports.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = idx_reg;
        if (state_reg == B_INIT)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == B_SWAPI)
        begin
            mem_we    = 1'b1;
            mem_waddr = i_reg;
            mem_wdata = rdata_b_reg;
        end
        else if (state_reg == B_SWAPJ)
        begin
            mem_we    = 1'b1;
            mem_waddr = mod_rem;
            mem_wdata = rdata_a_reg;
        end
    end

    assign rd_a_en   = (state_reg == B_PREAD) || load_en;
    assign rd_a_addr = (state_reg == B_EMIT) ? k_reg[AW-1:0] : i_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en)
        begin
            rdata_a_reg <= perm_mem[rd_a_addr];
        end
        if (state_reg == B_PREAD)
        begin
            rdata_b_reg <= perm_mem[mod_rem];
        end
        if (load_en)
        begin
            last_reg <= k_reg == (size_reg - SW'(1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign perm_value = VALUE_W'(rdata_a_reg);
    assign last_entry = last_reg;

`ifndef SYNTHESIS
    a_swap_partner_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PREAD) |-> (mod_rem < i_reg))
        else $error("swap partner not below swap index");

    a_last_after_all_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && last_reg) |-> (k_reg == size_reg))
        else $error("last entry left before the run was fully loaded");

    a_idle_output_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> !out_valid_reg)
        else $error("output still holds an entry while idle");
`endif

endmodule

/* hw/rtl/random_cyclic_permutation_shuffle_top.sv */
// Top level of the random cyclic permutation generator.
//
// Usage: feed one random byte per item on random_byte/in_valid/in_ready. Bytes
// fill indices 0 .. size-1 of the byte store; size comes from the perm_size
// register (cfg_wr_en/cfg_wr_data, zero acts as one, values above MAX_SIZE
// saturate). The byte that fills the last index closes the run: the back end
// loads the identity, then for i = size-1 down to 1 swaps entry i with entry
// byte[i] mod i; each swap reads the byte, runs the bit-serial remainder unit,
// reads both store entries and writes entry i and then entry byte[i] mod i.
// It then streams all size entries on perm_value with last_entry on the final
// one, one entry per cycle while out_ready is high. Earlier bytes give no item.
// Input is held off (in_ready low) from the closing byte until the swaps
// finish; bytes of the next run are taken while the entries stream out. A
// stalled receiver holds the output register and pauses the stream; nothing
// is dropped. Reset clears the byte count, sets perm_size to 64 and empties
// the run queue and output; store contents are not cleared.
module random_cyclic_permutation_shuffle_top #(
    parameter int MAX_SIZE = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rcps_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rcps_pkg::BYTE_W-1:0]   random_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rcps_pkg::VALUE_W-1:0]  perm_value,
    output logic                          last_entry
);
    import rcps_pkg::*;

    localparam int AW = $clog2(MAX_SIZE);
    localparam int SW = $clog2(MAX_SIZE + 1);

    // Run hand-off: the front pushes the run size, the back pops it.
    logic              q_push;
    logic [SW-1:0]     q_push_size;
    logic              q_pop;
    logic              q_valid;
    logic [SW-1:0]     q_size;

    // Byte store read path, driven by the back end during the swaps.
    logic              bytes_busy;
    logic [AW-1:0]     byte_rd_addr;
    logic [BYTE_W-1:0] byte_rdata;

    rcps_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .random_byte  (random_byte),
        .q_valid      (q_valid),
        .q_push       (q_push),
        .q_size       (q_push_size),
        .bytes_busy   (bytes_busy),
        .byte_rd_addr (byte_rd_addr),
        .byte_rdata   (byte_rdata)
    );

    rcps_queue #(
        .WIDTH (SW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_size),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_size)
    );

    rcps_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_size       (q_size),
        .q_pop        (q_pop),
        .bytes_busy   (bytes_busy),
        .byte_rd_addr (byte_rd_addr),
        .byte_rdata   (byte_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .perm_value   (perm_value),
        .last_entry   (last_entry)
    );

endmodule
